// File: sv/lld_pkg.sv
// Shared types, constants and command codes for the least-loaded dispatcher.
package lld_pkg;

    localparam int MAX_RESOURCES = 16;
    localparam int LOAD_WIDTH    = 32;
    localparam int RT_W          = 32;
    localparam int IDX_W         = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int CNT_W         = $clog2(MAX_RESOURCES + 1);
    localparam int SUM_W         = ((LOAD_WIDTH > RT_W) ? LOAD_WIDTH : RT_W) + 1;

    typedef logic [LOAD_WIDTH-1:0] t_load;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;

    // cell command codes
    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_ADD    = 2'd2;
    localparam logic [1:0] CMD_REBASE = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // request kinds
    localparam logic OP_SCHEDULE = 1'b0;
    localparam logic OP_REGISTER = 1'b1;

    // min-search token passed cell to cell
    typedef struct packed {
        logic  go;
        logic  have;
        t_load min;
        t_idx  idx;
    } t_tok;

    // update command broadcast to all cells
    typedef struct packed {
        logic [1:0] op;
        t_idx       sel;
        t_load      val;
    } t_cmd;

endpackage

// File: sv/lld_cell.sv
// One load cell: holds a resource load and forwards the min-search token.
module lld_cell
    import lld_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_idx i_idx,
    input  logic i_used,
    input  t_tok i_tok,
    input  t_cmd i_cmd,
    output t_tok o_tok
);

    t_load r_load;
    t_load n_load;
    t_tok  r_tok;
    t_tok  n_tok;
    logic  w_sel;

    assign w_sel = (i_cmd.sel == i_idx);

    // strict less-than keeps the lowest index on ties
    always_comb begin
        n_tok = i_tok;
        if (i_tok.go && i_used && (!i_tok.have || (r_load < i_tok.min))) begin
            n_tok.have = 1'b1;
            n_tok.min  = r_load;
            n_tok.idx  = i_idx;
        end
    end

    always_comb begin
        n_load = r_load;
        case (i_cmd.op)
            CMD_CLEAR:  if (w_sel) n_load = '0;
            CMD_ADD:    if (w_sel) n_load = r_load + i_cmd.val;
            CMD_REBASE: n_load = w_sel ? '0 : (r_load - i_cmd.val);
            default:    n_load = r_load;
        endcase
    end

    // only the token valid bit is reset; payload and load follow it
    always_ff @(posedge i_clk) begin
        r_tok.have <= n_tok.have;
        r_tok.min  <= n_tok.min;
        r_tok.idx  <= n_tok.idx;
        r_load     <= n_load;
        if (!i_rst_n) begin
            r_tok.go <= 1'b0;
        end else begin
            r_tok.go <= n_tok.go;
        end
    end

    assign o_tok = r_tok;

endmodule

// File: sv/least_loaded_dispatch_top.sv
// Least-loaded dispatcher: a row of load cells scanned by a travelling min token.
// Register request: a slot clear is issued (unless full), then the result is loaded out.
// Schedule request: S_LAUNCH, S_SCAN, S_DECIDE, S_FIN; the token walks one cell
// per cycle through the chain, then S_DECIDE checks overflow and the cells apply the update.
// One request at a time; next request is accepted once the result is loaded out.
// Reset (i_rst_n low, synchronous) empties the table; load contents are undefined.
module least_loaded_dispatch_top
    import lld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // [31:0] job_runtime, [32] estimate_valid
    input  logic        i_s_axis_tuser,   // [0] operation
    // result side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [3:0] resource_index
    output logic [2:0]  o_m_axis_tuser    // [1:0] status, [2] rescaled
);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LAUNCH = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    localparam logic [SUM_W-1:0] LOAD_MAX = {{(SUM_W-LOAD_WIDTH){1'b0}}, {LOAD_WIDTH{1'b1}}};

    logic [2:0]      r_state;
    logic [2:0]      n_state;
    t_cnt            r_count;
    t_cnt            n_count;
    t_cmd            r_cmd;
    t_cmd            n_cmd;
    logic [RT_W-1:0] r_rt;
    logic            r_est_vld;
    t_idx            r_best;
    t_load           r_min;
    t_idx            r_res_idx;
    t_idx            n_res_idx;
    logic [1:0]      r_res_st;
    logic [1:0]      n_res_st;
    logic            r_res_resc;
    logic            n_res_resc;
    logic            r_out_vld;
    logic [3:0]      r_out_idx;
    logic [1:0]      r_out_st;
    logic            r_out_resc;

    logic            w_acc;
    logic            w_op;
    logic            w_out_free;
    logic [SUM_W-1:0] w_sum;
    logic            w_ovf;
    logic [IDX_W+3:0] w_idx_ext;

    t_tok             w_tok  [MAX_RESOURCES+1];
    logic [MAX_RESOURCES-1:0] w_used;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign w_op            = i_s_axis_tuser;
    assign w_out_free      = !r_out_vld || i_m_axis_tready;

    // token enters cell 0 for one cycle; result pops out of the last cell
    assign w_tok[0].go   = (r_state == S_LAUNCH);
    assign w_tok[0].have = 1'b0;
    assign w_tok[0].min  = '0;
    assign w_tok[0].idx  = '0;

    for (genvar g = 0; g < MAX_RESOURCES; g++) begin : g_cell
        assign w_used[g] = (CNT_W'(g) < r_count);
        lld_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_used  (w_used[g]),
            .i_tok   (w_tok[g]),
            .i_cmd   (r_cmd),
            .o_tok   (w_tok[g+1])
        );
    end

    // overflow check: min + estimate must fit the counter
    assign w_sum = SUM_W'(r_min) + SUM_W'(r_rt);
    assign w_ovf = (w_sum > LOAD_MAX);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_cmd      = r_cmd;
        n_cmd.op   = CMD_NONE;   // commands last one cycle
        n_res_idx  = r_res_idx;
        n_res_st   = r_res_st;
        n_res_resc = r_res_resc;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_res_resc = 1'b0;
                    if (w_op == OP_REGISTER) begin
                        if (r_count == CNT_W'(MAX_RESOURCES)) begin
                            n_res_idx = '0;
                            n_res_st  = ST_FULL;
                        end else begin
                            n_cmd.op  = CMD_CLEAR;
                            n_cmd.sel = r_count[IDX_W-1:0];
                            n_count   = r_count + 1'b1;
                            n_res_idx = r_count[IDX_W-1:0];
                            n_res_st  = ST_OK;
                        end
                        n_state = S_FIN;
                    end else if (r_count == '0) begin
                        n_res_idx = '0;
                        n_res_st  = ST_EMPTY;
                        n_state   = S_FIN;
                    end else begin
                        n_state = S_LAUNCH;
                    end
                end
            end
            S_LAUNCH: n_state = S_SCAN;
            S_SCAN: begin
                if (w_tok[MAX_RESOURCES].go) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_res_idx = r_best;
                n_res_st  = ST_OK;
                if (r_est_vld) begin
                    n_cmd.sel = r_best;
                    if (w_ovf) begin
                        n_cmd.op   = CMD_REBASE;
                        n_cmd.val  = r_min;
                        n_res_resc = 1'b1;
                    end else begin
                        n_cmd.op  = CMD_ADD;
                        n_cmd.val = LOAD_WIDTH'(r_rt);
                    end
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command payload is not reset; only its opcode is
    always_ff @(posedge i_clk) begin
        r_cmd.sel <= n_cmd.sel;
        r_cmd.val <= n_cmd.val;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cmd.op  <= CMD_NONE;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cmd.op <= n_cmd.op;
            if (r_state == S_FIN && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign w_idx_ext = {4'b0000, r_res_idx};

    always_ff @(posedge i_clk) begin
        r_res_idx  <= n_res_idx;
        r_res_st   <= n_res_st;
        r_res_resc <= n_res_resc;
        if (w_acc) begin
            r_rt      <= i_s_axis_tdata[31:0];
            r_est_vld <= i_s_axis_tdata[32];
        end
        if (w_tok[MAX_RESOURCES].go) begin
            r_best <= w_tok[MAX_RESOURCES].idx;
            r_min  <= w_tok[MAX_RESOURCES].min;
        end
        if (r_state == S_FIN && w_out_free) begin
            r_out_idx  <= w_idx_ext[3:0];
            r_out_st   <= r_res_st;
            r_out_resc <= r_res_resc;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {4'b0000, r_out_idx};
    assign o_m_axis_tuser  = {r_out_resc, r_out_st};

endmodule

// File: tb/sv/least_loaded_dispatch_top_tb.sv
// Self-checking testbench for the least-loaded dispatcher top level.
module least_loaded_dispatch_top_tb
    import lld_pkg::*;
();

    localparam int CLK_HALF    = 10;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_PER_PHASE = 300;   // four idling phases, ~1200 random requests
    localparam int DRAIN_CYCLES = 40;        // idle margin after the queue drains
    localparam int CYCLE_LIMIT  = 1_000_000;

    typedef struct {
        logic [3:0] slot;
        logic [1:0] status;
        logic       rescaled;
    } t_dispatch_result;

    // Tracks the load table, predicts each dispatch decision and checks results in order.
    class dispatch_scoreboard;
        t_load            loads[MAX_RESOURCES];
        int unsigned      table_size;
        t_dispatch_result pending[$];
        int unsigned      errors;
        int unsigned      n_requests;
        int unsigned      n_registers;
        int unsigned      n_results;
        int unsigned      n_rescales;
        int unsigned      n_empty;
        int unsigned      n_full;
        int unsigned      n_no_estimate;

        function new();
            table_size    = 0;
            errors        = 0;
            n_requests    = 0;
            n_registers   = 0;
            n_results     = 0;
            n_rescales    = 0;
            n_empty       = 0;
            n_full        = 0;
            n_no_estimate = 0;
        endfunction

        // Accepted request: update the load table and queue the decision it yields.
        function void note_request(logic op, logic [31:0] runtime, logic est_ok);
            t_dispatch_result want;
            int               best;
            t_load            cur;
            logic [SUM_W-1:0] total;

            n_requests++;
            want.slot     = '0;
            want.status   = ST_OK;
            want.rescaled = 1'b0;
            if (op == OP_REGISTER) begin
                n_registers++;
                if (table_size >= MAX_RESOURCES) begin
                    want.status = ST_FULL;
                    n_full++;
                end else begin
                    loads[table_size] = '0;
                    want.slot = 4'(table_size);
                    table_size++;
                end
            end else if (table_size == 0) begin
                want.status = ST_EMPTY;
                n_empty++;
            end else begin
                // argmin, lowest index wins a tie
                best = 0;
                for (int i = 1; i < table_size; i++)
                    if (loads[i] < loads[best])
                        best = i;
                want.slot = 4'(best);
                if (!est_ok) begin
                    n_no_estimate++;
                end else begin
                    cur   = loads[best];
                    total = SUM_W'(cur) + SUM_W'(runtime);
                    if (total > SUM_W'(t_load'('1))) begin
                        // overflow: rebase everyone on the minimum, drop the estimate
                        for (int i = 0; i < table_size; i++)
                            if (i != best)
                                loads[i] = loads[i] - cur;
                        loads[best]   = '0;
                        want.rescaled = 1'b1;
                        n_rescales++;
                    end else begin
                        loads[best] = t_load'(total);
                    end
                end
            end
            pending.push_back(want);
        endfunction

        // Accepted result: compare against the oldest queued decision.
        function void check_result(logic [3:0] slot, logic [1:0] status, logic rescaled);
            t_dispatch_result want;

            n_results++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result slot=%0d status=%0d rescaled=%0b",
                         $time, slot, status, rescaled);
                return;
            end
            want = pending.pop_front();
            if (slot !== want.slot) begin
                errors++;
                $display("%0t: resource_index mismatch expected %0d actual %0d",
                         $time, want.slot, slot);
            end
            if (status !== want.status) begin
                errors++;
                $display("%0t: status mismatch expected %0d actual %0d",
                         $time, want.status, status);
            end
            if (rescaled !== want.rescaled) begin
                errors++;
                $display("%0t: rescaled mismatch expected %0b actual %0b",
                         $time, want.rescaled, rescaled);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata  = '0;   // [31:0] job_runtime, [32] estimate_valid
    logic        i_s_axis_tuser  = 1'b0; // [0] operation
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;         // [3:0] resource_index
    logic [2:0]  o_m_axis_tuser;         // [1:0] status, [2] rescaled

    // idling knobs, percent of cycles
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_count    = 0;

    dispatch_scoreboard sb;

    least_loaded_dispatch_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("least_loaded_dispatch_top verification failed");
            $finish;
        end
    end

    // Result side: values read here are the pre-edge ones, so the handshake
    // seen is the one the DUT sees at this edge. Ready is redrawn every cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata[3:0], o_m_axis_tuser[1:0], o_m_axis_tuser[2]);
        i_m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // Present one request and hold it until accepted. Valid is only dropped
    // inside an idle gap, so back-to-back requests keep it high.
    task automatic send_request(input logic op, input logic [31:0] runtime,
                                input logic est_ok);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'b0, est_ok, runtime};
        i_s_axis_tuser  <= op;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        sb.note_request(op, runtime, est_ok);
    endtask

    // Mostly schedule requests, runtimes mixed so that small increments,
    // near-full counters and outright overflow all show up.
    task automatic random_request();
        logic        op;
        logic        est_ok;
        logic [31:0] runtime;

        op     = ($urandom_range(99) < 3) ? OP_REGISTER : OP_SCHEDULE;
        est_ok = ($urandom_range(99) < 85);
        case ($urandom_range(9))
            0:       runtime = '0;
            1:       runtime = '1;
            2, 3:    runtime = $urandom;
            4, 5, 6: runtime = $urandom_range(1000);
            7, 8:    runtime = $urandom_range(32'hFFFF);
            default: runtime = 32'hFFFF_FFFF - $urandom_range(1000);
        endcase
        send_request(op, runtime, est_ok);
    endtask

    initial begin
        sb = new();

        // synchronous reset, held low from time zero, applied once
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, exact fit at the top of the counter,
        // overflow rebase, missing estimate, tie on equal loads.
        send_request(OP_SCHEDULE, 32'hFFFF_FFFF, 1'b1);  // nothing registered yet
        send_request(OP_SCHEDULE, 32'h0,         1'b0);
        send_request(OP_REGISTER, 32'h0,         1'b0);  // slot 0
        send_request(OP_SCHEDULE, 32'h0,         1'b1);
        send_request(OP_SCHEDULE, 32'hFFFF_FFFF, 1'b1);  // fills slot 0 exactly
        send_request(OP_REGISTER, 32'hFFFF_FFFF, 1'b1);  // slot 1
        send_request(OP_SCHEDULE, 32'd5,         1'b1);
        send_request(OP_SCHEDULE, 32'hFFFF_FFFF, 1'b0);  // no estimate, loads stay
        send_request(OP_SCHEDULE, 32'hFFFF_FFFF, 1'b1);  // overflow -> rebase
        send_request(OP_REGISTER, 32'h0,         1'b0);  // slot 2, ties with slot 1
        send_request(OP_SCHEDULE, 32'd100,       1'b1);
        send_request(OP_SCHEDULE, 32'd100,       1'b1);
        send_request(OP_SCHEDULE, 32'h8000_0000, 1'b1);
        send_request(OP_SCHEDULE, 32'h7FFF_FFFF, 1'b1);
        send_request(OP_SCHEDULE, 32'h8000_0000, 1'b1);  // overflows past the top -> rebase

        // Random phases: free-running, sender gaps, receiver stalls, both.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            repeat (RANDOM_PER_PHASE) random_request();
        end

        // make sure the full table was hit at least once
        while (sb.n_full == 0)
            send_request(OP_REGISTER, $urandom, 1'($urandom_range(1)));

        @(posedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests (%0d register), %0d results checked, final table size %0d.",
                 sb.n_requests, sb.n_registers, sb.n_results, sb.table_size);
        $display("Saw %0d rebases, %0d empty-table, %0d full-table, %0d without estimate.",
                 sb.n_rescales, sb.n_empty, sb.n_full, sb.n_no_estimate);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("least_loaded_dispatch_top verification clean");
        end else begin
            $display("least_loaded_dispatch_top verification failed");
        end
        $finish;
    end

endmodule
